/* hdl/ebpf_pkg.sv */
// ----------------------------------------------------------------------------
// ebpf_pkg
// Shared types and codes of the eBPF execute unit: item classes, the decoded
// item carried from the front end to the back end, and the result word.
// ----------------------------------------------------------------------------
package ebpf_pkg;

    // Instruction classes (opcode bits 2..0).
    localparam logic [2:0] CLS_LD    = 3'd0;
    localparam logic [2:0] CLS_LDX   = 3'd1;
    localparam logic [2:0] CLS_ST    = 3'd2;
    localparam logic [2:0] CLS_STX   = 3'd3;
    localparam logic [2:0] CLS_ALU32 = 3'd4;
    localparam logic [2:0] CLS_JMP   = 3'd5;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    // Whole opcodes with a special meaning.
    localparam logic [7:0] OPC_LDDW    = 8'h18;
    localparam logic [7:0] OPC_LDDW_DT = 8'hB8;
    localparam logic [7:0] OPC_LDDW_RO = 8'hD8;
    localparam logic [7:0] OPC_CALL    = 8'h85;
    localparam logic [7:0] OPC_EXIT    = 8'h95;
    localparam logic [7:0] OPC_LDXDW   = 8'h79;
    localparam logic [7:0] OPC_LDXW    = 8'h61;
    localparam logic [7:0] OPC_LDXH    = 8'h69;
    localparam logic [7:0] OPC_LDXB    = 8'h71;
    localparam logic [7:0] OPC_STDW    = 8'h7A;
    localparam logic [7:0] OPC_STW     = 8'h62;
    localparam logic [7:0] OPC_STH     = 8'h6A;
    localparam logic [7:0] OPC_STB     = 8'h72;
    localparam logic [7:0] OPC_STXDW   = 8'h7B;
    localparam logic [7:0] OPC_STXW    = 8'h63;
    localparam logic [7:0] OPC_STXH    = 8'h6B;
    localparam logic [7:0] OPC_STXB    = 8'h73;

    // ALU operations (opcode bits 7..4).
    localparam logic [3:0] ALU_ADD  = 4'h0;
    localparam logic [3:0] ALU_SUB  = 4'h1;
    localparam logic [3:0] ALU_MUL  = 4'h2;
    localparam logic [3:0] ALU_DIV  = 4'h3;
    localparam logic [3:0] ALU_OR   = 4'h4;
    localparam logic [3:0] ALU_AND  = 4'h5;
    localparam logic [3:0] ALU_LSH  = 4'h6;
    localparam logic [3:0] ALU_RSH  = 4'h7;
    localparam logic [3:0] ALU_NEG  = 4'h8;
    localparam logic [3:0] ALU_MOD  = 4'h9;
    localparam logic [3:0] ALU_XOR  = 4'hA;
    localparam logic [3:0] ALU_MOV  = 4'hB;
    localparam logic [3:0] ALU_ARSH = 4'hC;

    // Branch conditions (opcode bits 7..4).
    localparam logic [3:0] JMP_JA   = 4'h0;
    localparam logic [3:0] JMP_JEQ  = 4'h1;
    localparam logic [3:0] JMP_JGT  = 4'h2;
    localparam logic [3:0] JMP_JGE  = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;
    localparam logic [3:0] JMP_JNE  = 4'h5;
    localparam logic [3:0] JMP_JSGT = 4'h6;
    localparam logic [3:0] JMP_JSGE = 4'h7;
    localparam logic [3:0] JMP_JLT  = 4'hA;
    localparam logic [3:0] JMP_JLE  = 4'hB;
    localparam logic [3:0] JMP_JSLT = 4'hC;
    localparam logic [3:0] JMP_JSLE = 4'hD;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_CALL    = 3'd2;
    localparam logic [2:0] ST_EXIT    = 3'd3;
    localparam logic [2:0] ST_MEM     = 3'd4;

    // Wide load flavors.
    localparam logic [1:0] WK_PLAIN  = 2'd0;
    localparam logic [1:0] WK_DATA   = 2'd1;
    localparam logic [1:0] WK_RODATA = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CTX    = 2'd0;
    localparam logic [1:0] CFG_STACK  = 2'd1;
    localparam logic [1:0] CFG_DATA   = 2'd2;
    localparam logic [1:0] CFG_RODATA = 2'd3;

    localparam int REG_CTX   = 1;
    localparam int REG_STACK = 10;

    typedef enum logic [3:0] {
        K_START,
        K_WIDE1,
        K_WIDE2,
        K_ALU,
        K_JA,
        K_BRANCH,
        K_CALL,
        K_EXIT,
        K_MEM,
        K_ILLEGAL
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         op;
        logic               w32;
        logic               xsrc;
        logic [3:0]         a_idx;
        logic [3:0]         b_idx;
        logic signed [15:0] offset;
        logic [31:0]        imm;
        logic [1:0]         wkind;
    } item_t;

    typedef struct packed {
        logic [31:0] helper_id;
        logic [63:0] mem_address;
        logic [63:0] reg_value;
        logic [15:0] jump_offset;
        logic        taken;
        logic [2:0]  status;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WB
    } back_state_t;

endpackage

/* hdl/ebpf_front.sv */
// ----------------------------------------------------------------------------
// ebpf_front
// Decodes an incoming instruction word into a classified item and tracks
// whether the next word is the second half of a wide load.
// ----------------------------------------------------------------------------
module ebpf_front #(
    parameter int NUM_REGS = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                cmd,
    input  logic [7:0]          opcode,
    input  logic [3:0]          dst_index,
    input  logic [3:0]          src_index,
    input  logic signed [15:0]  offset,
    input  logic [31:0]         immediate,
    output ebpf_pkg::item_t     item
);
    import ebpf_pkg::*;

    logic       pend_reg, pend_next;
    logic [2:0] cls;
    logic [3:0] op;
    logic       xsrc, dok, sok, src_ok;

    function automatic logic idx_ok(input logic [3:0] idx);
        return {1'b0, idx} < 5'(NUM_REGS);
    endfunction

    function automatic logic br_ok(input logic [3:0] c);
        return c == JMP_JEQ || c == JMP_JGT || c == JMP_JGE || c == JMP_JSET ||
               c == JMP_JNE || c == JMP_JSGT || c == JMP_JSGE || c == JMP_JLT ||
               c == JMP_JLE || c == JMP_JSLT || c == JMP_JSLE;
    endfunction

    assign cls    = opcode[2:0];
    assign op     = opcode[7:4];
    assign xsrc   = opcode[3];
    assign dok    = idx_ok(dst_index);
    assign sok    = idx_ok(src_index);
    assign src_ok = !xsrc || sok;

    always_comb begin
        item        = '0;
        item.kind   = K_ILLEGAL;
        item.op     = op;
        item.w32    = (cls == CLS_ALU32);
        item.xsrc   = xsrc;
        item.a_idx  = dst_index;
        item.b_idx  = src_index;
        item.offset = offset;
        item.imm    = immediate;
        item.wkind  = WK_PLAIN;
        if (!cmd) begin
            item.kind = K_START;
        end else if (pend_reg) begin
            item.kind = K_WIDE2;
        end else begin
            unique case (cls)
                CLS_ALU32, CLS_ALU64: begin
                    if (dok && src_ok && op <= ALU_ARSH) item.kind = K_ALU;
                end
                CLS_JMP: begin
                    if (opcode == OPC_CALL) begin
                        item.kind = K_CALL;
                    end else if (opcode == OPC_EXIT) begin
                        item.kind  = K_EXIT;
                        item.a_idx = 4'd0;
                    end else if (op == JMP_JA) begin
                        if (!xsrc) item.kind = K_JA;
                    end else if (dok && src_ok && br_ok(op)) begin
                        item.kind = K_BRANCH;
                    end
                end
                CLS_LD: begin
                    if (dok && (opcode == OPC_LDDW || opcode == OPC_LDDW_DT ||
                                opcode == OPC_LDDW_RO)) begin
                        item.kind  = K_WIDE1;
                        item.wkind = (opcode == OPC_LDDW) ? WK_PLAIN :
                                     (opcode == OPC_LDDW_DT) ? WK_DATA : WK_RODATA;
                    end
                end
                CLS_LDX: begin
                    item.a_idx = src_index;
                    if (dok && sok && (opcode == OPC_LDXDW || opcode == OPC_LDXW ||
                                       opcode == OPC_LDXH || opcode == OPC_LDXB))
                        item.kind = K_MEM;
                end
                CLS_ST: begin
                    if (dok && (opcode == OPC_STDW || opcode == OPC_STW ||
                                opcode == OPC_STH || opcode == OPC_STB))
                        item.kind = K_MEM;
                end
                CLS_STX: begin
                    if (dok && sok && (opcode == OPC_STXDW || opcode == OPC_STXW ||
                                       opcode == OPC_STXH || opcode == OPC_STXB))
                        item.kind = K_MEM;
                end
                default: item.kind = K_ILLEGAL;
            endcase
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (accept) begin
            if (item.kind == K_WIDE1) pend_next = 1'b1;
            else if (item.kind == K_START || item.kind == K_WIDE2) pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

/* hdl/ebpf_queue.sv */
// ----------------------------------------------------------------------------
// ebpf_queue
// Two-entry queue of decoded items between the front end and the back end.
// ----------------------------------------------------------------------------
module ebpf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ebpf_pkg::item_t push_item,
    output logic            full,
    output logic            head_valid,
    input  logic            pop,
    output ebpf_pkg::item_t head_item
);
    import ebpf_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/ebpf_back.sv */
// ----------------------------------------------------------------------------
// ebpf_back
// Executes decoded items: register file, ALU, branch compare, a shared
// 32x32 multiplier stepped over three partial products, a bit-serial divider,
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module ebpf_back #(
    parameter int NUM_REGS = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            q_valid,
    input  ebpf_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output ebpf_pkg::res_t  m_res
);
    import ebpf_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    back_state_t state_reg, state_next;
    item_t       cur_reg;

    logic [63:0] cfg_reg [4];

    // Register file with registered reads and a valid bit per entry. An entry
    // not written since the last start reads as its start value.
    logic [63:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [63:0] r1_start_reg, r10_start_reg;
    logic [63:0] rda_reg, rdb_reg;
    logic        rva_reg, rvb_reg;
    logic [3:0]  ria_reg, rib_reg;
    logic [3:0]  addr_a, addr_b;
    logic [63:0] va, vb;

    logic [63:0] wide_low_reg;
    logic [3:0]  wide_dest_reg;
    logic [1:0]  wide_kind_reg;

    logic [63:0] a_op_reg, b_op_reg;
    logic [1:0]  step_reg;
    logic [63:0] prod_reg, acc_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg, quo_reg;
    logic [64:0] rem_sh;
    logic        rem_ge;

    res_t        res_reg;
    logic        wb_en_reg;
    logic [3:0]  wb_addr_reg;
    logic        m_valid_reg;
    res_t        m_res_reg;
    logic        out_free;

    // Execute-stage combinational values.
    logic [63:0] b_full, a_op, b_op, alu_r, imm64, off64, wide_r;
    logic [5:0]  sh;
    logic        cond;
    res_t        ex_res;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_fin;

    function automatic logic [63:0] rd_value(input logic v, input logic [3:0] i,
                                             input logic [63:0] d,
                                             input logic [63:0] r1,
                                             input logic [63:0] r10);
        logic [63:0] val;
        val = 64'd0;
        if (v) val = d;
        else if (i == 4'(REG_CTX)) val = r1;
        else if (i == 4'(REG_STACK)) val = r10;
        return val;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;

    assign addr_a = (state_reg == S_IDLE) ? q_item.a_idx : cur_reg.a_idx;
    assign addr_b = (state_reg == S_IDLE) ? q_item.b_idx : cur_reg.b_idx;
    assign va = rd_value(rva_reg, ria_reg, rda_reg, r1_start_reg, r10_start_reg);
    assign vb = rd_value(rvb_reg, rib_reg, rdb_reg, r1_start_reg, r10_start_reg);

    always_comb begin
        imm64  = {{32{cur_reg.imm[31]}}, cur_reg.imm};
        off64  = {{48{cur_reg.offset[15]}}, cur_reg.offset};
        b_full = cur_reg.xsrc ? vb : imm64;
        a_op   = cur_reg.w32 ? {32'd0, va[31:0]} : va;
        b_op   = cur_reg.w32 ? {32'd0, b_full[31:0]} : b_full;
        sh     = cur_reg.w32 ? {1'b0, b_op[4:0]} : b_op[5:0];

        unique case (cur_reg.op)
            ALU_ADD: alu_r = a_op + b_op;
            ALU_SUB: alu_r = a_op - b_op;
            ALU_DIV: alu_r = 64'd0;
            ALU_OR:  alu_r = a_op | b_op;
            ALU_AND: alu_r = a_op & b_op;
            ALU_LSH: alu_r = a_op << sh;
            ALU_RSH: alu_r = a_op >> sh;
            ALU_NEG: alu_r = 64'd0 - a_op;
            ALU_MOD: alu_r = a_op;
            ALU_XOR: alu_r = a_op ^ b_op;
            ALU_MOV: alu_r = b_op;
            ALU_ARSH: begin
                if (cur_reg.w32)
                    alu_r = {32'd0, 32'($signed(a_op[31:0]) >>> sh[4:0])};
                else
                    alu_r = 64'($signed(a_op) >>> sh);
            end
            default: alu_r = 64'd0;
        endcase
        if (cur_reg.w32) alu_r = {32'd0, alu_r[31:0]};

        unique case (cur_reg.op)
            JMP_JEQ:  cond = (va == b_full);
            JMP_JGT:  cond = (va > b_full);
            JMP_JGE:  cond = (va >= b_full);
            JMP_JSET: cond = ((va & b_full) != 64'd0);
            JMP_JNE:  cond = (va != b_full);
            JMP_JSGT: cond = ($signed(va) > $signed(b_full));
            JMP_JSGE: cond = ($signed(va) >= $signed(b_full));
            JMP_JLT:  cond = (va < b_full);
            JMP_JLE:  cond = (va <= b_full);
            JMP_JSLT: cond = ($signed(va) < $signed(b_full));
            JMP_JSLE: cond = ($signed(va) <= $signed(b_full));
            default:  cond = 1'b0;
        endcase

        wide_r = wide_low_reg + {cur_reg.imm, 32'd0};
        if (wide_kind_reg == WK_DATA) wide_r = wide_r + cfg_reg[CFG_DATA];
        else if (wide_kind_reg == WK_RODATA) wide_r = wide_r + cfg_reg[CFG_RODATA];

        ex_res = '0;
        unique case (cur_reg.kind)
            K_START, K_WIDE1: ex_res = '0;
            K_WIDE2:  ex_res.reg_value = wide_r;
            K_ALU:    ex_res.reg_value = alu_r;
            K_JA: begin
                ex_res.taken       = 1'b1;
                ex_res.jump_offset = cur_reg.offset;
            end
            K_BRANCH: begin
                ex_res.taken       = cond;
                ex_res.jump_offset = cur_reg.offset;
            end
            K_CALL: begin
                ex_res.status    = ST_CALL;
                ex_res.helper_id = cur_reg.imm;
            end
            K_EXIT: begin
                ex_res.status    = ST_EXIT;
                ex_res.reg_value = va;
            end
            K_MEM: begin
                ex_res.status      = ST_MEM;
                ex_res.mem_address = va + off64;
            end
            default: ex_res.status = ST_ILLEGAL;
        endcase
    end

    // Multiplier operand selection: low x low, low x high, high x low.
    always_comb begin
        unique case (step_reg)
            2'd0:    begin mul_x = a_op_reg[31:0];  mul_y = b_op_reg[31:0];  end
            2'd1:    begin mul_x = a_op_reg[31:0];  mul_y = b_op_reg[63:32]; end
            default: begin mul_x = a_op_reg[63:32]; mul_y = b_op_reg[31:0];  end
        endcase
        mul_fin = acc_reg + {prod_reg[31:0], 32'd0};
        rem_sh  = {rem_reg, quo_reg[63]};
        rem_ge  = rem_sh >= {1'b0, b_op_reg};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_EXEC;
            S_EXEC: begin
                if (cur_reg.kind == K_ALU && cur_reg.op == ALU_MUL)
                    state_next = S_MUL;
                else if (cur_reg.kind == K_ALU && b_op != 64'd0 &&
                         (cur_reg.op == ALU_DIV || cur_reg.op == ALU_MOD))
                    state_next = S_DIV;
                else
                    state_next = S_WB;
            end
            S_MUL: if (step_reg == 2'd3) state_next = S_WB;
            S_DIV: if (cnt_reg == 6'd63) state_next = S_WB;
            S_WB:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rda_reg <= rf_mem[addr_a[IDX_W-1:0]];
        rdb_reg <= rf_mem[addr_b[IDX_W-1:0]];
        if (state_reg == S_WB && out_free && wb_en_reg)
            rf_mem[wb_addr_reg[IDX_W-1:0]] <= res_reg.reg_value;
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        rva_reg <= vld_reg[addr_a[IDX_W-1:0]];
        rvb_reg <= vld_reg[addr_b[IDX_W-1:0]];
        ria_reg <= addr_a;
        rib_reg <= addr_b;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) cur_reg <= q_item;
            end
            S_EXEC: begin
                res_reg     <= ex_res;
                wb_en_reg   <= (cur_reg.kind == K_ALU) || (cur_reg.kind == K_WIDE2);
                wb_addr_reg <= (cur_reg.kind == K_WIDE2) ? wide_dest_reg : cur_reg.a_idx;
                a_op_reg    <= a_op;
                b_op_reg    <= b_op;
                step_reg    <= 2'd0;
                cnt_reg     <= 6'd0;
                rem_reg     <= 64'd0;
                quo_reg     <= a_op;
            end
            S_MUL: begin
                step_reg <= step_reg + 2'd1;
                prod_reg <= mul_x * mul_y;
                if (step_reg == 2'd1) acc_reg <= prod_reg;
                else if (step_reg == 2'd2) acc_reg <= mul_fin;
                if (step_reg == 2'd3)
                    res_reg.reg_value <= cur_reg.w32 ? {32'd0, mul_fin[31:0]} : mul_fin;
            end
            S_DIV: begin
                cnt_reg <= cnt_reg + 6'd1;
                rem_reg <= rem_ge ? 64'(rem_sh - {1'b0, b_op_reg}) : rem_sh[63:0];
                quo_reg <= {quo_reg[62:0], rem_ge};
                if (cnt_reg == 6'd63) begin
                    if (cur_reg.op == ALU_DIV)
                        res_reg.reg_value <= {quo_reg[62:0], rem_ge};
                    else
                        res_reg.reg_value <= rem_ge ? 64'(rem_sh - {1'b0, b_op_reg})
                                                    : rem_sh[63:0];
                end
            end
            S_WB: begin
                if (out_free) m_res_reg <= res_reg;
            end
            default: ;
        endcase
    end

    // Control state, configuration and architectural state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            vld_reg       <= '0;
            r1_start_reg  <= 64'd0;
            r10_start_reg <= 64'd0;
            wide_low_reg  <= 64'd0;
            wide_dest_reg <= 4'd0;
            wide_kind_reg <= WK_PLAIN;
            for (int i = 0; i < 4; i++) cfg_reg[i] <= 64'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) cfg_reg[cfg_index] <= cfg_data;
            if (state_reg == S_EXEC && cur_reg.kind == K_WIDE1) begin
                wide_low_reg  <= {32'd0, cur_reg.imm};
                wide_dest_reg <= cur_reg.a_idx;
                wide_kind_reg <= cur_reg.wkind;
            end
            if (state_reg == S_WB && out_free) begin
                m_valid_reg <= 1'b1;
                if (cur_reg.kind == K_START) begin
                    vld_reg       <= '0;
                    r1_start_reg  <= cfg_reg[CFG_CTX];
                    r10_start_reg <= cfg_reg[CFG_STACK];
                end else if (wb_en_reg) begin
                    vld_reg[wb_addr_reg[IDX_W-1:0]] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/ebpf_alu_branch_execute.sv */
// ----------------------------------------------------------------------------
// ebpf_alu_branch_execute
// eBPF instruction execute unit: ALU64/ALU32, 64-bit branches, wide loads,
// and reporting of call, exit and memory instructions.
// ----------------------------------------------------------------------------
// Usage:
// Instruction words arrive on the s_ stream; each accepted word yields exactly
// one result word on the m_ stream, in order. A word with cmd clear starts a
// new run: all registers clear, r1 takes context_pointer and r10 takes
// stack_top. The cfg_ port writes the four 64-bit base registers; the user
// must do so only while the unit is idle, which the block does not enforce.
// A front end decodes and classifies each word and pushes it into a
// two-entry queue, so input is taken while the back end works. The back end
// runs one word at a time: pop, register file read, execute, then write back
// into the output register. A multiply steps a 32x32 multiplier over three
// partial products, and a divide or modulo by a nonzero value produces one
// quotient bit per cycle.
// When the receiver stalls, the result holds in the output register, the
// back end waits in write-back, and the queue fills before s_tready drops.
// Reset is synchronous and active low; it clears the registers, the pending
// wide load and the configuration, and leaves both streams empty.
// ----------------------------------------------------------------------------
module ebpf_alu_branch_execute #(
    parameter int NUM_REGS = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration write port.
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    // Instruction stream.
    input  logic          s_tvalid,
    output logic          s_tready,
    // Fields from bit 0: cmd(1), opcode(8), dst_index(4), src_index(4),
    // offset(16), immediate(32), then zero fill.
    input  logic [71:0]   s_tdata,
    // Result stream.
    output logic          m_tvalid,
    input  logic          m_tready,
    // Fields from bit 0: status(3), taken(1), jump_offset(16), reg_value(64),
    // mem_address(64), helper_id(32), then zero fill.
    output logic [183:0]  m_tdata
);
    import ebpf_pkg::*;

    item_t dec_item, head_item;
    logic  q_full, q_valid, q_pop, accept;
    res_t  res;

    // An item is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ebpf_front #(.NUM_REGS(NUM_REGS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (s_tdata[0]),
        .opcode    (s_tdata[8:1]),
        .dst_index (s_tdata[12:9]),
        .src_index (s_tdata[16:13]),
        .offset    (s_tdata[32:17]),
        .immediate (s_tdata[64:33]),
        .item      (dec_item)
    );

    ebpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_item  (dec_item),
        .full       (q_full),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head_item  (head_item)
    );

    ebpf_back #(.NUM_REGS(NUM_REGS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    // The result struct is declared lowest field last, so it packs directly.
    assign m_tdata = {4'd0, res};

endmodule
